/* rtl/lsg3_pkg.sv */
// shared types for the least-squares gradient block
// command and status records between controller and datapath
// no dependencies
package lsg3_pkg;

  // entries 0..5 hold the moment matrix, 6..8 the right-hand side
  localparam int ST_DEPTH = 9;
  localparam int ST_IW = 4;
  localparam int ST_RHS = 6;

  // multiplier digit size and steps over a 64-bit operand
  localparam int MUL_DIG = 8;
  localparam int MUL_STEPS = 64 / MUL_DIG;
  localparam int MUL_CW = $clog2(MUL_STEPS);

  typedef enum logic [1:0] {
    SRC_ST = 2'd0,
    SRC_Y  = 2'd1,
    SRC_DU = 2'd2,
    SRC_T  = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    WB_NONE = 3'd0,
    WB_MOM  = 3'd1,
    WB_NUM  = 3'd2,
    WB_TSET = 3'd3,
    WB_TSUB = 3'd4,
    WB_R    = 3'd5,
    WB_RHS  = 3'd6,
    WB_GRAD = 3'd7
  } wb_t;

  typedef struct packed {
    logic             load;
    logic             ld_a;
    logic             ld_b;
    logic             div_go;
    logic             div_short;
    logic             emit;
    wb_t              wb;
    src_t             rd_src;
    logic [ST_IW-1:0] rd_idx;
    logic             nsq_clr;
    logic             nsq_add;
    logic             r_clr;
    logic             r_neg;
    logic             d_save;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic nsq_zero;
    logic det_zero;
  } sts_t;

endpackage

/* rtl/lsg3_mul.sv */
// digit-serial signed multiplier, 8 bits of the second operand per cycle
// depends on lsg3_pkg
module lsg3_mul #(
  parameter int WW = 212
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic signed [WW-1:0] a,
  input  logic signed [63:0]   b,
  output logic                 done,
  output logic signed [WW-1:0] p
);
  import lsg3_pkg::*;

  logic [WW-1:0]     ma_r;
  logic [63:0]       mb_r;
  logic [WW-1:0]     acc_r;
  logic              neg_r;
  logic [MUL_CW-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [WW-1:0]     step_p;

  assign step_p = ma_r * mb_r[MUL_DIG-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MUL_CW'(MUL_STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      ma_r  <= a[WW-1] ? WW'(-a) : WW'(a);
      mb_r  <= b[63] ? 64'(-b) : 64'(b);
      neg_r <= a[WW-1] ^ b[63];
      acc_r <= '0;
    end else if (run_r) begin
      acc_r <= acc_r + step_p;
      ma_r  <= ma_r << MUL_DIG;
      mb_r  <= mb_r >> MUL_DIG;
    end
  end

  assign done = done_r;
  assign p    = neg_r ? -$signed(acc_r) : $signed(acc_r);

endmodule

/* rtl/lsg3_div.sv */
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// short mode iterates only over the low SHORT_BITS bits of the numerator
// depends on nothing
module lsg3_div #(
  parameter int WW = 212,
  parameter int SHORT_BITS = 81
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic                 short_mode,
  input  logic signed [WW-1:0] num,
  input  logic signed [WW-1:0] den,
  output logic                 done,
  output logic signed [WW-1:0] q
);
  localparam int CW = $clog2(WW + 1);

  logic [WW-1:0] n_r;
  logic [WW-1:0] d_r;
  logic [WW-1:0] rem_r;
  logic [WW-1:0] q_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [WW-1:0] nmag;
  logic [WW:0]   rem_s;
  logic          qbit;

  assign nmag  = num[WW-1] ? WW'(-num) : WW'(num);
  assign rem_s = {rem_r, n_r[WW-1]};
  assign qbit  = (rem_s >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= short_mode ? CW'(SHORT_BITS) : CW'(WW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      n_r   <= short_mode ? (nmag << (WW - SHORT_BITS)) : nmag;
      d_r   <= den[WW-1] ? WW'(-den) : WW'(den);
      neg_r <= num[WW-1] ^ den[WW-1];
      rem_r <= '0;
      q_r   <= '0;
    end else if (run_r) begin
      rem_r <= qbit ? WW'(rem_s - {1'b0, d_r}) : rem_s[WW-1:0];
      n_r   <= n_r << 1;
      q_r   <= {q_r[WW-2:0], qbit};
    end
  end

  assign done = done_r;
  assign q    = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

/* rtl/lsg3_dp.sv */
// datapath: input registers, accumulators, operand port, multiplier and divider
// depends on lsg3_pkg, lsg3_mul, lsg3_div
module lsg3_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsg3_pkg::cmd_t       cmd,
  output lsg3_pkg::sts_t       sts,
  input  logic signed [31:0]   in_offset_x,
  input  logic signed [31:0]   in_offset_y,
  input  logic signed [31:0]   in_offset_z,
  input  logic signed [31:0]   in_center_value,
  input  logic signed [31:0]   in_neighbor_value,
  output logic                 out_valid,
  output logic signed [31:0]   out_grad_x,
  output logic signed [31:0]   out_grad_y,
  output logic signed [31:0]   out_grad_z,
  output logic                 out_singular
);
  import lsg3_pkg::*;

  localparam int WW = 196 + FRAC_BITS;
  localparam int TW = 130;
  localparam int RW = 194;
  localparam int NW = 66;
  localparam int SHORT_BITS = 65 + FRAC_BITS;

  logic signed [31:0]   y_r [3];
  logic signed [32:0]   du_r;
  logic signed [63:0]   st_r [ST_DEPTH];
  logic [63:0]          nsq_r;
  logic signed [TW-1:0] t_r;
  logic signed [RW-1:0] r_r;
  logic signed [RW-1:0] d_r;
  logic signed [NW-1:0] num_r;
  logic signed [WW-1:0] opa_r;
  logic signed [31:0]   g_r [3];
  logic                 out_valid_r;
  logic signed [31:0]   out_gx_r;
  logic signed [31:0]   out_gy_r;
  logic signed [31:0]   out_gz_r;
  logic                 out_sing_r;

  logic signed [63:0]   st_rd;
  logic signed [WW-1:0] rd_data;
  logic                 mul_done;
  logic signed [WW-1:0] mul_p;
  logic                 div_done;
  logic signed [WW-1:0] div_q;
  logic signed [WW-1:0] p_shift;
  logic signed [WW-1:0] r_base;
  logic signed [WW-1:0] r_new;
  logic signed [WW-1:0] div_num;
  logic signed [WW-1:0] div_den;
  logic                 sing;

  function automatic logic signed [63:0] sat64(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] v);
    logic [WW-32:0] hi;
    hi = v[WW-1:31];
    if (hi == '0 || (&hi)) begin
      return v[31:0];
    end
    return v[WW-1] ? 32'sh80000000 : 32'sh7fffffff;
  endfunction

  assign st_rd = st_r[cmd.rd_idx];

  always_comb begin
    unique case (cmd.rd_src)
      SRC_ST:  rd_data = WW'(st_rd);
      SRC_Y:   rd_data = WW'(y_r[cmd.rd_idx[1:0]]);
      SRC_DU:  rd_data = WW'(du_r);
      SRC_T:   rd_data = WW'(t_r);
      default: rd_data = '0;
    endcase
  end

  assign p_shift = mul_p >>> FRAC_BITS;
  assign r_base  = cmd.r_clr ? '0 : WW'(r_r);
  assign r_new   = r_base + (cmd.r_neg ? -mul_p : mul_p);
  assign div_num = cmd.div_short ? (WW'(num_r) <<< FRAC_BITS) : (WW'(r_r) <<< FRAC_BITS);
  assign div_den = cmd.div_short ? $signed({{(WW-64){1'b0}}, nsq_r}) : WW'(d_r);
  assign sing    = (d_r == '0);

  lsg3_mul #(.WW(WW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.ld_b),
    .a     (opa_r),
    .b     ($signed(rd_data[63:0])),
    .done  (mul_done),
    .p     (mul_p)
  );

  lsg3_div #(.WW(WW), .SHORT_BITS(SHORT_BITS)) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (cmd.div_go),
    .short_mode (cmd.div_short),
    .num        (div_num),
    .den        (div_den),
    .done       (div_done),
    .q          (div_q)
  );

  // accumulators clear on reset and after each result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ST_DEPTH; i++) begin
        st_r[i] <= '0;
      end
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.emit) begin
        for (int i = 0; i < ST_DEPTH; i++) begin
          st_r[i] <= '0;
        end
      end else if (cmd.wb == WB_MOM) begin
        st_r[cmd.rd_idx] <= sat64(st_rd, p_shift[63:0]);
      end else if (cmd.wb == WB_RHS) begin
        st_r[cmd.rd_idx] <= sat64(st_rd, div_q[63:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y_r[0] <= in_offset_x;
      y_r[1] <= in_offset_y;
      y_r[2] <= in_offset_z;
      du_r   <= 33'(in_neighbor_value) - 33'(in_center_value);
    end
    if (cmd.ld_a) begin
      opa_r <= rd_data;
    end
    if (cmd.nsq_add) begin
      nsq_r <= (cmd.nsq_clr ? 64'd0 : nsq_r) + mul_p[63:0];
    end
    unique case (cmd.wb)
      WB_NUM:  num_r <= mul_p[NW-1:0];
      WB_TSET: t_r <= mul_p[TW-1:0];
      WB_TSUB: t_r <= t_r - mul_p[TW-1:0];
      WB_R: begin
        r_r <= r_new[RW-1:0];
        if (cmd.d_save) begin
          d_r <= r_new[RW-1:0];
        end
      end
      WB_GRAD: g_r[cmd.rd_idx[1:0]] <= sat32(div_q);
      default: ;
    endcase
    if (cmd.emit) begin
      out_gx_r   <= sing ? 32'sd0 : g_r[0];
      out_gy_r   <= sing ? 32'sd0 : g_r[1];
      out_gz_r   <= sing ? 32'sd0 : g_r[2];
      out_sing_r <= sing;
    end
  end

  assign sts.mul_done = mul_done;
  assign sts.div_done = div_done;
  assign sts.nsq_zero = (nsq_r == 64'd0);
  assign sts.det_zero = sing;

  assign out_valid    = out_valid_r;
  assign out_grad_x   = out_gx_r;
  assign out_grad_y   = out_gy_r;
  assign out_grad_z   = out_gz_r;
  assign out_singular = out_sing_r;

endmodule

/* rtl/lsg3_ctrl.sv */
// controller: sequences side accumulation and the cramer solve
// depends on lsg3_pkg
module lsg3_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_use_side,
  input  logic           in_last_side,
  output logic           busy,
  output lsg3_pkg::cmd_t cmd,
  input  lsg3_pkg::sts_t sts
);
  import lsg3_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_FA   = 10'b0000000010,
    S_FB   = 10'b0000000100,
    S_MW   = 10'b0000001000,
    S_WB   = 10'b0000010000,
    S_DGO  = 10'b0000100000,
    S_DW   = 10'b0001000000,
    S_DWB  = 10'b0010000000,
    S_CHK  = 10'b0100000000,
    S_EMIT = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] op_r, op_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] j_r, j_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic       solve_r, solve_nxt;
  logic       last_r, last_nxt;

  src_t             a_src, b_src;
  logic [ST_IW-1:0] a_idx, b_idx;
  wb_t              wb_k;
  logic [1:0]       cp, cq;

  function automatic logic [1:0] pair_i(input logic [3:0] e);
    unique case (e)
      4'd0, 4'd1, 4'd2: return 2'd0;
      4'd3, 4'd4:       return 2'd1;
      default:          return 2'd2;
    endcase
  endfunction

  function automatic logic [1:0] pair_j(input logic [3:0] e);
    unique case (e)
      4'd0:       return 2'd0;
      4'd1, 4'd3: return 2'd1;
      default:    return 2'd2;
    endcase
  endfunction

  // symmetric layout: xx xy xz yy yz zz
  function automatic logic [ST_IW-1:0] msel(input logic [1:0] r, input logic [1:0] c);
    unique case ({r, c})
      4'b0000:         return ST_IW'(0);
      4'b0001, 4'b0100: return ST_IW'(1);
      4'b0010, 4'b1000: return ST_IW'(2);
      4'b0101:         return ST_IW'(3);
      4'b0110, 4'b1001: return ST_IW'(4);
      default:         return ST_IW'(5);
    endcase
  endfunction

  // column k-1 of the matrix is replaced by the rhs for k > 0
  function automatic logic [ST_IW-1:0] elem(input logic [1:0] r, input logic [1:0] c,
                                            input logic [1:0] k);
    if (k != 2'd0 && c == k - 2'd1) begin
      return ST_IW'(ST_RHS) + ST_IW'(r);
    end
    return msel(r, c);
  endfunction

  assign cp = (j_r == 2'd0) ? 2'd1 : 2'd0;
  assign cq = (j_r == 2'd2) ? 2'd1 : 2'd2;

  always_comb begin
    a_src = SRC_ST;
    b_src = SRC_ST;
    a_idx = '0;
    b_idx = '0;
    wb_k  = WB_NONE;
    if (!solve_r) begin
      if (op_r < 4'd6) begin
        a_src = SRC_Y;
        a_idx = ST_IW'(pair_i(op_r));
        b_src = SRC_Y;
        b_idx = ST_IW'(pair_j(op_r));
        wb_k  = WB_MOM;
      end else begin
        a_src = SRC_DU;
        b_src = SRC_Y;
        b_idx = ST_IW'(op_r - 4'd6);
        wb_k  = WB_NUM;
      end
    end else begin
      unique case (sub_r)
        2'd0: begin
          a_idx = elem(2'd1, cp, k_r);
          b_idx = elem(2'd2, cq, k_r);
          wb_k  = WB_TSET;
        end
        2'd1: begin
          a_idx = elem(2'd1, cq, k_r);
          b_idx = elem(2'd2, cp, k_r);
          wb_k  = WB_TSUB;
        end
        default: begin
          a_src = SRC_T;
          b_idx = elem(2'd0, j_r, k_r);
          wb_k  = WB_R;
        end
      endcase
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    op_nxt    = op_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    sub_nxt   = sub_r;
    solve_nxt = solve_r;
    last_nxt  = last_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          last_nxt  = in_last_side;
          op_nxt    = '0;
          k_nxt     = '0;
          j_nxt     = '0;
          sub_nxt   = '0;
          solve_nxt = !in_use_side;
          if (in_use_side || in_last_side) begin
            state_nxt = S_FA;
          end
        end
      end
      S_FA: begin
        cmd.rd_src = a_src;
        cmd.rd_idx = a_idx;
        cmd.ld_a   = 1'b1;
        state_nxt  = S_FB;
      end
      S_FB: begin
        cmd.rd_src = b_src;
        cmd.rd_idx = b_idx;
        cmd.ld_b   = 1'b1;
        state_nxt  = S_MW;
      end
      S_MW: begin
        if (sts.mul_done) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb     = wb_k;
        cmd.rd_src = SRC_ST;
        cmd.rd_idx = op_r;
        if (!solve_r) begin
          if (op_r < 4'd6) begin
            cmd.nsq_add = (op_r == 4'd0) || (op_r == 4'd3) || (op_r == 4'd5);
            cmd.nsq_clr = (op_r == 4'd0);
            op_nxt      = op_r + 4'd1;
            state_nxt   = S_FA;
          end else if (!sts.nsq_zero) begin
            state_nxt = S_DGO;
          end else if (op_r != 4'd8) begin
            op_nxt    = op_r + 4'd1;
            state_nxt = S_FA;
          end else if (last_r) begin
            solve_nxt = 1'b1;
            state_nxt = S_FA;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.r_clr  = (j_r == 2'd0);
          cmd.r_neg  = (j_r == 2'd1);
          cmd.d_save = (k_r == 2'd0) && (j_r == 2'd2);
          if (sub_r != 2'd2) begin
            sub_nxt   = sub_r + 2'd1;
            state_nxt = S_FA;
          end else begin
            sub_nxt = '0;
            if (j_r != 2'd2) begin
              j_nxt     = j_r + 2'd1;
              state_nxt = S_FA;
            end else begin
              j_nxt     = '0;
              state_nxt = (k_r == 2'd0) ? S_CHK : S_DGO;
            end
          end
        end
      end
      S_DGO: begin
        cmd.div_go    = 1'b1;
        cmd.div_short = !solve_r;
        state_nxt     = S_DW;
      end
      S_DW: begin
        cmd.div_short = !solve_r;
        if (sts.div_done) begin
          state_nxt = S_DWB;
        end
      end
      S_DWB: begin
        cmd.rd_src = SRC_ST;
        if (!solve_r) begin
          cmd.wb     = WB_RHS;
          cmd.rd_idx = op_r;
          if (op_r != 4'd8) begin
            op_nxt    = op_r + 4'd1;
            state_nxt = S_FA;
          end else if (last_r) begin
            solve_nxt = 1'b1;
            state_nxt = S_FA;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          cmd.wb     = WB_GRAD;
          cmd.rd_idx = ST_IW'(k_r - 2'd1);
          if (k_r == 2'd3) begin
            state_nxt = S_EMIT;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = S_FA;
          end
        end
      end
      S_CHK: begin
        if (sts.det_zero) begin
          state_nxt = S_EMIT;
        end else begin
          k_nxt     = 2'd1;
          state_nxt = S_FA;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        solve_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= '0;
      k_r     <= '0;
      j_r     <= '0;
      sub_r   <= '0;
      solve_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      sub_r   <= sub_nxt;
      solve_r <= solve_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

/* rtl/least_squares_gradient_3d_top.sv */
// Least-squares cell gradient, 3D, Q(FRAC_BITS) fixed point. One request per
// cell side is taken when start is high and busy is low. A skipped side that
// is not the last returns to idle at once (busy stays low). A used side runs
// nine products on the shared multiplier, which retires 8 bits of its second
// operand per cycle, and up to three divisions on the one-bit-per-cycle
// divider. The last side then solves by Cramer's rule: 36 products plus
// three divisions, or only the nine determinant products when the matrix
// is singular. The result shows on the out_ ports for exactly one cycle
// with out_valid high; the receiver cannot stall it. A singular matrix
// gives zero and out_singular.
// depends on lsg3_pkg, lsg3_ctrl, lsg3_dp
module least_squares_gradient_3d_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  input  logic signed [31:0] in_offset_z,
  input  logic signed [31:0] in_center_value,
  input  logic signed [31:0] in_neighbor_value,
  input  logic               in_use_side,
  input  logic               in_last_side,
  output logic               out_valid,
  output logic signed [31:0] out_grad_x,
  output logic signed [31:0] out_grad_y,
  output logic signed [31:0] out_grad_z,
  output logic               out_singular
);
  import lsg3_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lsg3_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_use_side  (in_use_side),
    .in_last_side (in_last_side),
    .busy         (busy),
    .cmd          (cmd),
    .sts          (sts)
  );

  lsg3_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_offset_x       (in_offset_x),
    .in_offset_y       (in_offset_y),
    .in_offset_z       (in_offset_z),
    .in_center_value   (in_center_value),
    .in_neighbor_value (in_neighbor_value),
    .out_valid         (out_valid),
    .out_grad_x        (out_grad_x),
    .out_grad_y        (out_grad_y),
    .out_grad_z        (out_grad_z),
    .out_singular      (out_singular)
  );

endmodule

/* rtl/lsg3_chk.sv */
// port-level checks for the least-squares gradient block
// bound to least_squares_gradient_3d_top
module lsg3_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_use_side,
  input logic        in_last_side,
  input logic        out_valid,
  input logic [31:0] out_grad_x,
  input logic [31:0] out_grad_y,
  input logic [31:0] out_grad_z,
  input logic        out_singular
);

  // results never come in consecutive cycles
  a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |->
      (out_grad_x == 32'd0 && out_grad_y == 32'd0 && out_grad_z == 32'd0))
    else $error("singular result with nonzero gradient");

  // a skipped, non-final side is absorbed without going busy
  a_skip_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_use_side && !in_last_side) |=> !busy)
    else $error("skipped side made the block busy");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_last_side) |=> busy)
    else $error("final side did not start a solve");

  a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding work");

endmodule

bind least_squares_gradient_3d_top lsg3_chk u_lsg3_chk (.*);
